// ===== src/tvn_pkg.sv =====
// Shared types, constants and fixed-point helpers for the torus vertex/normal generator.
// No dependencies; used by tvn_sine, the top level and the testbench.
`default_nettype none

package tvn_pkg;

  // Register map, one 32-bit word per register.
  typedef enum logic [1:0] {
    REG_SEG_CNT  = 2'd0,
    REG_RING_CNT = 2'd1,
    REG_MAJOR    = 2'd2,
    REG_MINOR    = 2'd3
  } cfg_idx_t;

  localparam logic [9:0]  SEG_CNT_RST  = 10'd16;
  localparam logic [9:0]  RING_CNT_RST = 10'd16;
  localparam logic [14:0] MAJOR_RST    = 15'd19661;
  localparam logic [14:0] MINOR_RST    = 15'd6554;

  // Quarter-wave polynomial coefficients, Q30.
  localparam logic [30:0] Q30_ONE = 31'd1073741824;
  localparam logic [30:0] C_A1    = 31'd1686629713;
  localparam logic [30:0] C_A3    = 31'd693598670;
  localparam logic [30:0] C_A5    = 31'd85569306;
  localparam logic [30:0] C_A7    = 31'd5026995;
  localparam logic [30:0] C_A9    = 31'd172273;

  localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;

  // Register stages through the sine unit.
  localparam int SINE_LAT = 7;

  // Round to nearest by n bits, ties away from zero.
  function automatic logic signed [63:0] rnd_s64(input logic signed [63:0] v,
                                                 input int unsigned n);
    logic signed [63:0] half;
    logic signed [63:0] res;
    half = 64'sd1 <<< (n - 1);
    if (v >= 0) begin
      res = (v + half) >>> n;
    end else begin
      res = -((-v + half) >>> n);
    end
    return res;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
    logic signed [15:0] res;
    if (v > 64'sd32767) begin
      res = 16'sh7fff;
    end else if (v < -64'sd32768) begin
      res = 16'sh8000;
    end else begin
      res = v[15:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== src/tvn_phase_div.sv =====
// Pipelined restoring divider: phase = floor((index mod count) * 2^32 / count).
// Depends on nothing but its parameter; four quotient steps per register stage.
`default_nettype none

module tvn_phase_div #(
  parameter int IB = 10
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [IB:0]   dividend,
  input  wire logic [IB-1:0] divisor,
  output logic      [31:0]   phase
);

  localparam int DB  = IB + 33;
  localparam int K   = 4;
  localparam int NS  = (DB + K - 1) / K;
  localparam int DBP = NS * K;

  logic [IB-1:0]  rem_r [NS];
  logic [DBP-1:0] dvd_r [NS];
  logic [31:0]    q_r   [NS];

  logic [IB-1:0]  rem_nxt [NS];
  logic [DBP-1:0] dvd_nxt [NS];
  logic [31:0]    q_nxt   [NS];

  // The long division runs over the integer bits first, which leaves the
  // remainder index mod count; the last 32 quotient bits are the phase.
  for (genvar s = 0; s < NS; s++) begin : g_stage
    always_comb begin
      logic [IB-1:0]  r;
      logic [DBP-1:0] d;
      logic [31:0]    q;
      logic [IB:0]    trial;
      if (s == 0) begin
        r = '0;
        d = DBP'({dividend, 32'h0});
        q = '0;
      end else begin
        r = rem_r[s-1];
        d = dvd_r[s-1];
        q = q_r[s-1];
      end
      for (int k = 0; k < K; k++) begin
        trial = {r, d[DBP-1]};
        d = d << 1;
        if (trial >= {1'b0, divisor}) begin
          r = IB'(trial - {1'b0, divisor});
          q = {q[30:0], 1'b1};
        end else begin
          r = trial[IB-1:0];
          q = {q[30:0], 1'b0};
        end
      end
      rem_nxt[s] = r;
      dvd_nxt[s] = d;
      q_nxt[s]   = q;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s] <= rem_nxt[s];
        dvd_r[s] <= dvd_nxt[s];
        q_r[s]   <= q_nxt[s];
      end
    end
  end

  assign phase = q_r[NS-1];

endmodule

`default_nettype wire

// ===== src/tvn_sine.sv =====
// Pipelined fixed-point sine of a 32-bit phase, result signed Q30.
// Depends on tvn_pkg for the polynomial coefficients.
`default_nettype none

module tvn_sine (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic        [31:0] phase,
  output logic signed      [31:0] value
);

  logic [30:0] u_r   [6];
  logic [30:0] t_r   [1:5];
  logic [30:0] u2_r  [2:4];
  logic        neg_r [6];
  logic signed [31:0] value_r;

  logic [30:0] u_nxt;
  logic [61:0] sq;
  logic [61:0] hp [4];
  logic [30:0] t_nxt [4];
  logic [61:0] fin;
  logic [30:0] res;

  // Odd quadrants mirror the argument, the upper half negates.
  assign u_nxt = phase[30] ? (tvn_pkg::Q30_ONE - {1'b0, phase[29:0]})
                           : {1'b0, phase[29:0]};
  assign sq = 62'(u_r[0]) * 62'(u_r[0]);

  // Horner steps, one per stage; u^2 travels beside each step.
  always_comb begin
    hp[0] = 62'(t_r[1]) * 62'(tvn_pkg::C_A9);
    t_nxt[0] = tvn_pkg::C_A7 - hp[0][60:30];
    hp[1] = 62'(u2_r[2]) * 62'(t_r[2]);
    t_nxt[1] = tvn_pkg::C_A5 - hp[1][60:30];
    hp[2] = 62'(u2_r[3]) * 62'(t_r[3]);
    t_nxt[2] = tvn_pkg::C_A3 - hp[2][60:30];
    hp[3] = 62'(u2_r[4]) * 62'(t_r[4]);
    t_nxt[3] = tvn_pkg::C_A1 - hp[3][60:30];
  end

  assign fin = 62'(u_r[5]) * 62'(t_r[5]);
  assign res = (fin[61:30] > 32'(tvn_pkg::Q30_ONE)) ? tvn_pkg::Q30_ONE : fin[60:30];

  always_ff @(posedge clk) begin
    if (en) begin
      u_r[0]   <= u_nxt;
      neg_r[0] <= phase[31];
      for (int k = 1; k < 6; k++) begin
        u_r[k]   <= u_r[k-1];
        neg_r[k] <= neg_r[k-1];
      end
      t_r[1]  <= sq[60:30];
      u2_r[2] <= t_r[1];
      u2_r[3] <= u2_r[2];
      u2_r[4] <= u2_r[3];
      t_r[2] <= t_nxt[0];
      t_r[3] <= t_nxt[1];
      t_r[4] <= t_nxt[2];
      t_r[5] <= t_nxt[3];
      value_r <= neg_r[5] ? -$signed({1'b0, res}) : $signed({1'b0, res});
    end
  end

  assign value = value_r;

endmodule

`default_nettype wire

// ===== src/torus_vertex_normal_generator_unit.sv =====
// Torus strip vertex and normal generator: top level with register port and pipeline.
// Depends on tvn_pkg, tvn_phase_div and tvn_sine.
// Path: an accepted request passes the job register, ceil((INDEX_BITS+33)/4) divider stages,
// 7 sine stages and the w, product and output register stages before its first vertex leaves.
// Throughput: one vertex per cycle while the output is not stalled; each request gives two.
// Reset: synchronous active-low rst_n clears valid bits and loads register defaults.
`default_nettype none

module torus_vertex_normal_generator_unit #(
  parameter int INDEX_BITS = 10
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // ring_index [IB-1:0], segment_index [2*IB-1:IB], zero fill
  input  wire logic [((2*INDEX_BITS+7)/8)*8-1:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, 16 bits each from bit 0
  output logic [95:0]      out_tdata,
  output logic             out_tlast,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  localparam int IB  = INDEX_BITS;
  localparam int NS  = (IB + 33 + 3) / 4;
  localparam int D1  = NS + tvn_pkg::SINE_LAT;

  // Configuration registers
  logic [9:0]  seg_cnt_r, ring_cnt_r;
  logic [14:0] major_r, minor_r;
  tvn_pkg::cfg_idx_t cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = tvn_pkg::cfg_idx_t'(cfg_paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_cnt_r  <= tvn_pkg::SEG_CNT_RST;
      ring_cnt_r <= tvn_pkg::RING_CNT_RST;
      major_r    <= tvn_pkg::MAJOR_RST;
      minor_r    <= tvn_pkg::MINOR_RST;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      unique case (cfg_idx)
        tvn_pkg::REG_SEG_CNT:  seg_cnt_r  <= cfg_pwdata[9:0];
        tvn_pkg::REG_RING_CNT: ring_cnt_r <= cfg_pwdata[9:0];
        tvn_pkg::REG_MAJOR:    major_r    <= cfg_pwdata[14:0];
        tvn_pkg::REG_MINOR:    minor_r    <= cfg_pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      tvn_pkg::REG_SEG_CNT:  cfg_prdata = {22'h0, seg_cnt_r};
      tvn_pkg::REG_RING_CNT: cfg_prdata = {22'h0, ring_cnt_r};
      tvn_pkg::REG_MAJOR:    cfg_prdata = {17'h0, major_r};
      tvn_pkg::REG_MINOR:    cfg_prdata = {17'h0, minor_r};
      default:               cfg_prdata = '0;
    endcase
  end

  // Counts as the index width sees them; a zero count acts as one.
  logic [IB+9:0] seg_ext, ring_ext;
  logic [IB-1:0] seg_div, ring_div;

  assign seg_ext  = {{IB{1'b0}}, seg_cnt_r};
  assign ring_ext = {{IB{1'b0}}, ring_cnt_r};
  assign seg_div  = (seg_ext[IB-1:0] == '0) ? IB'(1) : seg_ext[IB-1:0];
  assign ring_div = (ring_ext[IB-1:0] == '0) ? IB'(1) : ring_ext[IB-1:0];

  // Pipeline advance: everything moves when the output slot is free or drains.
  logic en;
  assign en = !out_tvalid || out_tready;

  // Job issue: ring i+1 first, then ring i.
  logic          second_r;
  logic [IB-1:0] ring_hold_r, seg_hold_r;
  logic          job_vld_r, job_last_r;
  logic [IB:0]   job_ring_r;
  logic [IB-1:0] job_seg_r;

  assign in_tready = en && !second_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      second_r  <= 1'b0;
      job_vld_r <= 1'b0;
    end else if (en) begin
      if (second_r) begin
        second_r  <= 1'b0;
        job_vld_r <= 1'b1;
      end else begin
        second_r  <= in_tvalid;
        job_vld_r <= in_tvalid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (second_r) begin
        job_ring_r <= {1'b0, ring_hold_r};
        job_seg_r  <= seg_hold_r;
        job_last_r <= 1'b1;
      end else begin
        job_ring_r  <= {1'b0, in_tdata[IB-1:0]} + (IB+1)'(1);
        job_seg_r   <= in_tdata[2*IB-1:IB];
        job_last_r  <= 1'b0;
        ring_hold_r <= in_tdata[IB-1:0];
        seg_hold_r  <= in_tdata[2*IB-1:IB];
      end
    end
  end

  // Phases and trigonometry
  logic [31:0] ph_s, ph_t;
  logic signed [31:0] cs, ss, ct, st;

  tvn_phase_div #(.IB(IB)) u_div_ring (
    .clk(clk), .en(en), .dividend(job_ring_r), .divisor(ring_div), .phase(ph_s)
  );
  tvn_phase_div #(.IB(IB)) u_div_seg (
    .clk(clk), .en(en), .dividend({1'b0, job_seg_r}), .divisor(seg_div), .phase(ph_t)
  );

  tvn_sine u_cos_s (.clk(clk), .en(en), .phase(ph_s + tvn_pkg::QUARTER_TURN), .value(cs));
  tvn_sine u_sin_s (.clk(clk), .en(en), .phase(ph_s), .value(ss));
  tvn_sine u_cos_t (.clk(clk), .en(en), .phase(ph_t + tvn_pkg::QUARTER_TURN), .value(ct));
  tvn_sine u_sin_t (.clk(clk), .en(en), .phase(ph_t), .value(st));

  // Valid and last travel alongside the divider and sine stages.
  logic vld_r [D1];
  logic lst_r [D1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < D1; k++) vld_r[k] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= job_vld_r;
      for (int k = 1; k < D1; k++) vld_r[k] <= vld_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lst_r[0] <= job_last_r;
      for (int k = 1; k < D1; k++) lst_r[k] <= lst_r[k-1];
    end
  end

  // Stage one: tube offset w and the y components.
  logic signed [47:0] rc_prod, rs_prod;
  logic signed [63:0] w_full;
  logic p1_vld_r, p1_lst_r;
  logic signed [31:0] w_r, cs1_r, ct1_r, st1_r;
  logic signed [15:0] posy1_r;
  logic signed [16:0] ny1_r;

  assign rc_prod = $signed({33'h0, minor_r}) * 48'(cs);
  assign rs_prod = $signed({33'h0, minor_r}) * 48'(ss);
  assign w_full  = $signed({19'h0, major_r, 30'h0} >> 15)
                 + tvn_pkg::rnd_s64(64'(rc_prod), 15);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r <= 1'b0;
    end else if (en) begin
      p1_vld_r <= vld_r[D1-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_lst_r <= lst_r[D1-1];
      w_r      <= w_full[31:0];
      cs1_r    <= cs;
      ct1_r    <= ct;
      st1_r    <= st;
      posy1_r  <= tvn_pkg::sat16(tvn_pkg::rnd_s64(64'(rs_prod), 31));
      ny1_r    <= 17'(tvn_pkg::rnd_s64(64'(ss), 16));
    end
  end

  // Stage two: the four products.
  logic p2_vld_r, p2_lst_r, p2_wz_r, p2_wneg_r;
  logic signed [63:0] mwx_r, mwz_r, mcx_r, mcz_r;
  logic signed [15:0] posy2_r;
  logic signed [16:0] ny2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p2_vld_r <= 1'b0;
    end else if (en) begin
      p2_vld_r <= p1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p2_lst_r  <= p1_lst_r;
      p2_wz_r   <= (w_r == 32'sd0);
      p2_wneg_r <= w_r[31];
      mwx_r     <= 64'(w_r) * 64'(ct1_r);
      mwz_r     <= 64'(w_r) * 64'(st1_r);
      mcx_r     <= 64'(cs1_r) * 64'(ct1_r);
      mcz_r     <= 64'(cs1_r) * 64'(st1_r);
      posy2_r   <= posy1_r;
      ny2_r     <= ny1_r;
    end
  end

  // Stage three: rounding, sign of the normal, saturation, output register.
  logic signed [63:0] rnx, rnz, rny;
  logic signed [15:0] nx, ny, nz;

  always_comb begin
    rnx = tvn_pkg::rnd_s64(mcx_r, 46);
    rnz = tvn_pkg::rnd_s64(mcz_r, 46);
    rny = 64'(ny2_r);
    if (p2_wz_r) begin
      nx = '0;
      ny = '0;
      nz = '0;
    end else if (p2_wneg_r) begin
      nx = tvn_pkg::sat16(-rnx);
      ny = tvn_pkg::sat16(-rny);
      nz = tvn_pkg::sat16(-rnz);
    end else begin
      nx = tvn_pkg::sat16(rnx);
      ny = tvn_pkg::sat16(rny);
      nz = tvn_pkg::sat16(rnz);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid <= 1'b0;
    end else if (en) begin
      out_tvalid <= p2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_tlast <= p2_lst_r;
      out_tdata <= {nz, ny, nx,
                    tvn_pkg::sat16(tvn_pkg::rnd_s64(mwz_r, 46)),
                    posy2_r,
                    tvn_pkg::sat16(tvn_pkg::rnd_s64(mwx_r, 46))};
    end
  end

endmodule

`default_nettype wire

// ===== test/tvn_checker.sv =====
// Checker for the torus vertex and normal generator: follows register writes, predicts
// both strip vertices of every accepted request and compares them with the output stream.
// Depends on tvn_pkg for register indexes, reset values and polynomial coefficients.
`default_nettype none

module tvn_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [23:0] in_tdata,
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [95:0] out_tdata,
  input  wire logic        out_tlast,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  input  wire logic        cfg_pready,
  output int               mismatch_count,
  output int               vertices_pending,
  output int               vertices_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [15:0] norm_z;
    logic signed [15:0] norm_y;
    logic signed [15:0] norm_x;
    logic signed [15:0] pos_z;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_x;
  } vertex_t;

  typedef struct {
    vertex_t vtx;
    logic    last;
  } strip_vertex_t;

  logic [9:0]  seg_count;
  logic [9:0]  ring_count;
  logic [14:0] major_r;
  logic [14:0] minor_r;

  strip_vertex_t expected_vertices[$];

  assign vertices_pending = expected_vertices.size();

  function automatic longint round_near(longint v, int n);
    longint half;
    half = longint'(1) << (n - 1);
    if (v >= 0) return (v + half) >>> n;
    return -((-v + half) >>> n);
  endfunction

  function automatic logic signed [15:0] clip16(longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic longint quarter_wave(longint unsigned u);
    longint unsigned u2, t, res;
    u2 = (u * u) >> 30;
    t = tvn_pkg::C_A9;
    t = tvn_pkg::C_A7 - ((u2 * t) >> 30);
    t = tvn_pkg::C_A5 - ((u2 * t) >> 30);
    t = tvn_pkg::C_A3 - ((u2 * t) >> 30);
    t = tvn_pkg::C_A1 - ((u2 * t) >> 30);
    res = (u * t) >> 30;
    if (res > tvn_pkg::Q30_ONE) res = tvn_pkg::Q30_ONE;
    return longint'(res);
  endfunction

  function automatic longint sine_of(logic [31:0] p);
    longint v;
    if (p[30]) v = quarter_wave(longint'(tvn_pkg::Q30_ONE) - longint'(p[29:0]));
    else v = quarter_wave(longint'(p[29:0]));
    return p[31] ? -v : v;
  endfunction

  function automatic logic [31:0] turn_phase(int unsigned idx, logic [9:0] cnt);
    longint unsigned n, m;
    n = (cnt == 0) ? 1 : cnt;
    m = idx % n;
    return 32'((m << 32) / n);
  endfunction

  function automatic vertex_t torus_vertex(int unsigned ring, longint ct, longint st);
    logic [31:0] ps;
    longint cs, ss, rr, w, sg;
    vertex_t v;
    ps = turn_phase(ring, ring_count);
    cs = sine_of(ps + tvn_pkg::QUARTER_TURN);
    ss = sine_of(ps);
    rr = minor_r;
    w = (longint'(major_r) << 15) + round_near(rr * cs, 15);
    v.pos_x = clip16(round_near(w * ct, 46));
    v.pos_y = clip16(round_near(rr * ss, 31));
    v.pos_z = clip16(round_near(w * st, 46));
    if (w == 0) begin
      v.norm_x = '0;
      v.norm_y = '0;
      v.norm_z = '0;
    end else begin
      sg = (w > 0) ? 1 : -1;
      v.norm_x = clip16(sg * round_near(cs * ct, 46));
      v.norm_y = clip16(sg * round_near(ss, 16));
      v.norm_z = clip16(sg * round_near(cs * st, 46));
    end
    return v;
  endfunction

  always @(posedge clk) begin
    logic [31:0] pt;
    longint ct, st;
    int unsigned ring;
    strip_vertex_t sv;
    vertex_t got;
    if (!rst_n) begin
      seg_count  <= tvn_pkg::SEG_CNT_RST;
      ring_count <= tvn_pkg::RING_CNT_RST;
      major_r    <= tvn_pkg::MAJOR_RST;
      minor_r    <= tvn_pkg::MINOR_RST;
      expected_vertices.delete();
      mismatch_count   <= 0;
      vertices_checked <= 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (tvn_pkg::cfg_idx_t'(cfg_paddr[3:2]))
          tvn_pkg::REG_SEG_CNT:  seg_count  <= cfg_pwdata[9:0];
          tvn_pkg::REG_RING_CNT: ring_count <= cfg_pwdata[9:0];
          tvn_pkg::REG_MAJOR:    major_r    <= cfg_pwdata[14:0];
          tvn_pkg::REG_MINOR:    minor_r    <= cfg_pwdata[14:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        ring = in_tdata[9:0];
        pt = turn_phase(in_tdata[19:10], seg_count);
        ct = sine_of(pt + tvn_pkg::QUARTER_TURN);
        st = sine_of(pt);
        // The outer ring comes first and is not wrapped to the field width.
        sv.vtx = torus_vertex(ring + 1, ct, st);
        sv.last = 1'b0;
        expected_vertices.push_back(sv);
        sv.vtx = torus_vertex(ring, ct, st);
        sv.last = 1'b1;
        expected_vertices.push_back(sv);
      end
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (expected_vertices.size() == 0) begin
          if (mismatch_count < 10)
            $display("[%0t] unexpected vertex %h last=%b", $realtime, out_tdata, out_tlast);
          mismatch_count <= mismatch_count + 1;
        end else begin
          sv = expected_vertices.pop_front();
          if (got !== sv.vtx || out_tlast !== sv.last) begin
            if (mismatch_count < 10) begin
              $display("[%0t] vertex mismatch", $realtime);
              $display("  expected pos %0d %0d %0d norm %0d %0d %0d last %b",
                       sv.vtx.pos_x, sv.vtx.pos_y, sv.vtx.pos_z,
                       sv.vtx.norm_x, sv.vtx.norm_y, sv.vtx.norm_z, sv.last);
              $display("  actual   pos %0d %0d %0d norm %0d %0d %0d last %b",
                       got.pos_x, got.pos_y, got.pos_z,
                       got.norm_x, got.norm_y, got.norm_z, out_tlast);
            end
            mismatch_count <= mismatch_count + 1;
          end
          vertices_checked <= vertices_checked + 1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== test/torus_vertex_normal_generator_unit_tb.sv =====
// Testbench top for the torus vertex and normal generator: clock, reset, register
// writes, request stimulus and output back-pressure; checking lives in tvn_checker.
// Depends on tvn_pkg, tvn_checker and the block itself.
`default_nettype none

module torus_vertex_normal_generator_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [95:0] out_tdata;
  logic        out_tlast;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [3:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  int mismatch_count, vertices_pending, vertices_checked;
  int cycle_count = 0;
  int requests_sent = 0;
  bit stimulus_done = 1'b0;
  bit pressure_done = 1'b0;

  always #5 clk = ~clk;

  torus_vertex_normal_generator_unit u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  tvn_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_pready(cfg_pready),
    .mismatch_count(mismatch_count), .vertices_pending(vertices_pending),
    .vertices_checked(vertices_checked)
  );

  // In the second of every four equal blocks of cycle_count neither side idles; otherwise either may idle at random.
  function automatic bit idle_now();
    if ((cycle_count / 1000) % 4 == 1) return 1'b0;
    return $urandom_range(0, 99) < 20;
  endfunction

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Receiver: one hold-off early on, a long one in the middle of random traffic so
  // that the block fills and stalls its input, and random stalls otherwise.
  initial begin
    int held;
    out_tready <= 1'b0;
    wait (rst_n);
    for (held = 0; held < 150; held++) @(posedge clk);
    forever begin
      if (!pressure_done && requests_sent >= 250) begin
        pressure_done = 1'b1;
        out_tready <= 1'b0;
        for (held = 0; held < 200; held++) @(posedge clk);
      end
      out_tready <= !idle_now();
      @(posedge clk);
    end
  end

  task automatic reg_write(tvn_pkg::cfg_idx_t idx, logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic set_torus(int segs, int rings, int major, int minor);
    reg_write(tvn_pkg::REG_SEG_CNT, segs);
    reg_write(tvn_pkg::REG_RING_CNT, rings);
    reg_write(tvn_pkg::REG_MAJOR, major);
    reg_write(tvn_pkg::REG_MINOR, minor);
  endtask

  // Waits for every outstanding vertex, then lets the pipeline settle.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (vertices_pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic send_request(int ring, int seg);
    in_tvalid <= 1'b1;
    in_tdata  <= {4'b0, seg[9:0], ring[9:0]};
    do @(negedge clk); while (!in_tready);
    @(posedge clk);
    requests_sent++;
    if (idle_now()) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while (idle_now());
    end
  endtask

  initial begin
    int k, n, big;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Default torus: field extremes, ring wrap past the count, index above count.
    send_request(0, 0);
    send_request(1023, 1023);
    send_request(15, 15);
    send_request(16, 3);
    send_request(682, 341);
    drain();
    // Spindle torus with zero major radius: normals vanish where the tube crosses the axis.
    set_torus(4, 4, 0, 20000);
    for (k = 0; k < 4; k++) send_request(k, k);
    drain();
    // Major equals minor radius: the inner ring sits exactly on the axis.
    set_torus(8, 2, 16384, 16384);
    send_request(0, 1);
    send_request(1, 2);
    drain();
    // Both radii zero, and zero tube radius alone.
    set_torus(0, 0, 0, 0);
    send_request(5, 9);
    drain();
    reg_write(tvn_pkg::REG_MAJOR, 20000);
    send_request(1023, 0);
    drain();
    // Largest radii overflow the position range; full-size counts.
    set_torus(1023, 1023, 32767, 32767);
    send_request(0, 0);
    send_request(1022, 511);
    send_request(1023, 256);
    send_request(500, 767);
    drain();
    set_torus(1, 1, 32767, 0);
    send_request(1023, 1023);
    drain();

    for (int phase = 0; phase < 6; phase++) begin
      big = $urandom_range(0, 3) == 0;
      set_torus(big ? $urandom_range(0, 1023) : $urandom_range(1, 40),
                big ? $urandom_range(0, 1023) : $urandom_range(1, 40),
                $urandom_range(0, 32767), $urandom_range(0, 32767));
      n = 145;
      for (k = 0; k < n; k++) begin
        if ($urandom_range(0, 3) == 0)
          send_request($urandom_range(0, 1023), $urandom_range(0, 1023));
        else
          send_request($urandom_range(0, 63), $urandom_range(0, 63));
      end
      drain();
    end
    stimulus_done = 1'b1;
  end

  initial begin
    wait (stimulus_done);
    $display("%0d requests over several torus shapes, %0d vertices compared",
             requests_sent, vertices_checked);
    if (mismatch_count == 0 && vertices_pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

`default_nettype wire
